### src/qli_pkg.sv
// ----------------------------------------------------------------------------
// qli_pkg - shared types and codes of the quadratic Lagrange interpolator
// Holds the transaction structs of both channels and the status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qli_pkg;

  typedef struct packed {
    logic        [47:0] query_time;
    logic        [47:0] time_a;
    logic signed [31:0] value_a;
    logic        [47:0] time_b;
    logic signed [31:0] value_b;
    logic        [47:0] time_c;
    logic signed [31:0] value_c;
  } qli_query_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic        [2:0]  status;
  } qli_result_t;

  localparam logic [2:0] STATUS_OK    = 3'd0;
  localparam logic [2:0] STATUS_EQUAL = 3'd1;
  localparam logic [2:0] STATUS_RANGE = 3'd2;
  localparam logic [2:0] STATUS_ORDER = 3'd3;
  localparam logic [2:0] STATUS_SPAN  = 3'd4;

  // quotient bits kept by the divider; larger quotients saturate
  localparam int Q_BITS = 33;

endpackage

`default_nettype wire

### src/qli_front.sv
// ----------------------------------------------------------------------------
// qli_front - timestamp checks and operand preparation
// Classifies a query and forms the offsets, magnitudes and term signs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qli_front
  import qli_pkg::*;
#(
  parameter int SPAN_BITS = 24,
  parameter int CMD_W     = 3 + 96 + 3 + 6 * SPAN_BITS
) (
  input  qli_query_t       query,
  output logic [CMD_W-1:0] cmd
);

  logic [47:0] t_lo, t_hi, span, dq, d1;
  logic [2:0]  status;
  logic [SPAN_BITS-1:0] x, h1, h2, d, dx1, dx2;
  logic        below1, n0, n1, n2;
  logic [31:0] a0, a1, a2;

  always_comb begin
    t_lo = query.time_a;
    if (query.time_b < t_lo) t_lo = query.time_b;
    if (query.time_c < t_lo) t_lo = query.time_c;
    t_hi = query.time_a;
    if (query.time_b > t_hi) t_hi = query.time_b;
    if (query.time_c > t_hi) t_hi = query.time_c;
    span = query.time_c - query.time_a;
    if (query.time_a == query.time_b || query.time_a == query.time_c ||
        query.time_b == query.time_c) begin
      status = STATUS_EQUAL;
    end else if (query.query_time < t_lo || query.query_time > t_hi) begin
      status = STATUS_RANGE;
    end else if (!(query.time_a < query.time_b && query.time_b < query.time_c)) begin
      status = STATUS_ORDER;
    end else if (span[47:SPAN_BITS] != '0) begin
      status = STATUS_SPAN;
    end else begin
      status = STATUS_OK;
    end
  end

  assign dq     = query.query_time - query.time_a;
  assign d1     = query.time_b - query.time_a;
  assign x      = dq[SPAN_BITS-1:0];
  assign h1     = d1[SPAN_BITS-1:0];
  assign h2     = span[SPAN_BITS-1:0];
  assign d      = h2 - h1;
  assign below1 = x < h1;
  assign dx1    = below1 ? h1 - x : x - h1;
  assign dx2    = h2 - x;

  assign n0 = query.value_a[31];
  assign n1 = query.value_b[31];
  assign n2 = query.value_c[31];
  assign a0 = n0 ? 32'(-query.value_a) : 32'(query.value_a);
  assign a1 = n1 ? 32'(-query.value_b) : 32'(query.value_b);
  assign a2 = n2 ? 32'(-query.value_c) : 32'(query.value_c);

  assign cmd = {status, a0, a1, a2,
                n0 ^ below1 ^ (dx2 != '0), n1, n2 ^ below1,
                x, dx1, dx2, h1, h2, d};

endmodule

`default_nettype wire

### src/qli_queue.sv
// ----------------------------------------------------------------------------
// qli_queue - small register FIFO between front and back
// Decouples query acceptance from the arithmetic pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qli_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty,
  output logic         full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;

  assign empty = (count == '0);
  assign full  = (count == (AW+1)'(DEPTH));
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end

endmodule

`default_nettype wire

### src/qli_back.sv
// ----------------------------------------------------------------------------
// qli_back - product, sum and division pipeline
// Forms numerator and denominator, divides one quotient bit per stage,
// rounds and saturates into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qli_back
  import qli_pkg::*;
#(
  parameter int SPAN_BITS = 24,
  parameter int CMD_W     = 3 + 96 + 3 + 6 * SPAN_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CMD_W-1:0] head,
  input  logic             empty,
  output logic             pop,
  output logic             result_valid,
  input  logic             result_stall,
  output qli_result_t      result
);

  localparam int SB  = SPAN_BITS;
  localparam int PAW = 32 + SB;
  localparam int PBW = 2 * SB;
  localparam int TW  = 32 + 3 * SB;
  localparam int DW  = 3 * SB;
  localparam int NW  = 3 * SB + 34;
  localparam int RW  = DW + 1;
  localparam int NST = 5 + Q_BITS;

  logic advance;
  logic [NST-1:0] vld;

  assign advance = !result_valid || !result_stall;
  assign pop     = advance && !empty;

  // unpack command
  logic [2:0]  c_status;
  logic [31:0] c_a0, c_a1, c_a2;
  logic        c_n0, c_n1, c_n2;
  logic [SB-1:0] c_x, c_dx1, c_dx2, c_h1, c_h2, c_d;

  assign {c_status, c_a0, c_a1, c_a2, c_n0, c_n1, c_n2,
          c_x, c_dx1, c_dx2, c_h1, c_h2, c_d} = head;

  // stage 1: first products
  logic [PAW-1:0] pa0, pa1, pa2;
  logic [PBW-1:0] pb0, pb1, pb2, dh;
  logic [SB-1:0]  dd;
  logic [2:0]     neg1, st1;

  always_ff @(posedge clk) begin
    if (advance) begin
      pa0  <= PAW'(c_a0) * PAW'(c_dx1);
      pa1  <= PAW'(c_a1) * PAW'(c_x);
      pa2  <= PAW'(c_a2) * PAW'(c_x);
      pb0  <= PBW'(c_dx2) * PBW'(c_d);
      pb1  <= PBW'(c_dx2) * PBW'(c_h2);
      pb2  <= PBW'(c_dx1) * PBW'(c_h1);
      dh   <= PBW'(c_h1) * PBW'(c_h2);
      dd   <= c_d;
      neg1 <= {c_n2, c_n1, c_n0};
      st1  <= c_status;
    end
  end

  // stage 2: 32x32 partial products
  logic [63:0] ea [3];
  logic [63:0] eb [3];
  logic [63:0] pp [3][4];
  logic [63:0] edh;
  logic [63:0] dp0, dp1;
  logic [2:0]  neg2, st2;

  assign ea[0] = 64'(pa0);
  assign ea[1] = 64'(pa1);
  assign ea[2] = 64'(pa2);
  assign eb[0] = 64'(pb0);
  assign eb[1] = 64'(pb1);
  assign eb[2] = 64'(pb2);
  assign edh   = 64'(dh);

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        pp[k][0] <= 64'(ea[k][31:0])  * 64'(eb[k][31:0]);
        pp[k][1] <= 64'(ea[k][31:0])  * 64'(eb[k][63:32]);
        pp[k][2] <= 64'(ea[k][63:32]) * 64'(eb[k][31:0]);
        pp[k][3] <= 64'(ea[k][63:32]) * 64'(eb[k][63:32]);
      end
      dp0  <= 64'(edh[31:0])  * 64'(dd);
      dp1  <= 64'(edh[63:32]) * 64'(dd);
      neg2 <= neg1;
      st2  <= st1;
    end
  end

  // stage 3: sum partial products
  logic [TW-1:0] term [3];
  logic [DW-1:0] den3;
  logic [2:0]    neg3, st3;
  logic [127:0]  tsum [3];
  logic [127:0]  dsum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tsum[k] = 128'(pp[k][0]) + (128'(pp[k][1]) << 32) +
                (128'(pp[k][2]) << 32) + (128'(pp[k][3]) << 64);
    end
    dsum = 128'(dp0) + (128'(dp1) << 32);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        term[k] <= tsum[k][TW-1:0];
      end
      den3 <= dsum[DW-1:0];
      neg3 <= neg2;
      st3  <= st2;
    end
  end

  // stage 4: signed numerator
  logic [NW-1:0] num4;
  logic [NW-1:0] sterm [3];
  logic [DW-1:0] den4;
  logic [2:0]    st4;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sterm[k] = neg3[k] ? NW'(-NW'(term[k])) : NW'(term[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      num4 <= sterm[0] + sterm[1] + sterm[2];
      den4 <= den3;
      st4  <= st3;
    end
  end

  // stage 5: magnitude, overflow check, divider seed
  logic [NW-1:0] mag;
  assign mag = num4[NW-1] ? NW'(-num4) : num4;

  logic [RW-1:0]     dr   [Q_BITS+1];
  logic [Q_BITS-1:0] dlo  [Q_BITS+1];
  logic [Q_BITS-1:0] dq   [Q_BITS+1];
  logic [DW-1:0]     dden [Q_BITS+1];
  logic              dsg  [Q_BITS+1];
  logic              dovf [Q_BITS+1];
  logic [2:0]        dst  [Q_BITS+1];

  always_ff @(posedge clk) begin
    if (advance) begin
      dr[0]   <= mag[NW-1:Q_BITS];
      dlo[0]  <= mag[Q_BITS-1:0];
      dq[0]   <= '0;
      dden[0] <= den4;
      dsg[0]  <= num4[NW-1];
      dovf[0] <= mag[NW-1:Q_BITS] >= RW'(den4);
      dst[0]  <= st4;
    end
  end

  // divider: one quotient bit per stage
  for (genvar j = 0; j < Q_BITS; j++) begin : g_div
    logic [RW-1:0] r2;
    logic          ge;
    assign r2 = {dr[j][DW-1:0], dlo[j][Q_BITS-1]};
    assign ge = r2 >= RW'(dden[j]);
    always_ff @(posedge clk) begin
      if (advance) begin
        dr[j+1]   <= ge ? r2 - RW'(dden[j]) : r2;
        dlo[j+1]  <= {dlo[j][Q_BITS-2:0], 1'b0};
        dq[j+1]   <= {dq[j][Q_BITS-2:0], ge};
        dden[j+1] <= dden[j];
        dsg[j+1]  <= dsg[j];
        dovf[j+1] <= dovf[j];
        dst[j+1]  <= dst[j];
      end
    end
  end

  // round and saturate
  logic              rnd;
  logic [Q_BITS:0]   qr;
  logic [31:0]       sat_val;
  logic [Q_BITS-1:0] qf;

  assign qf  = dq[Q_BITS];
  assign rnd = {dr[Q_BITS][DW-1:0], 1'b0} >= RW'(dden[Q_BITS]);
  assign qr  = (Q_BITS+1)'(qf) + (Q_BITS+1)'(rnd);

  always_comb begin
    if (dsg[Q_BITS]) begin
      if (dovf[Q_BITS] || qr > (Q_BITS+1)'(33'h080000000)) begin
        sat_val = 32'h80000000;
      end else begin
        sat_val = 32'(-qr[31:0]);
      end
    end else begin
      if (dovf[Q_BITS] || qr > (Q_BITS+1)'(33'h07FFFFFFF)) begin
        sat_val = 32'h7FFFFFFF;
      end else begin
        sat_val = qr[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.status       <= dst[Q_BITS];
      result.result_value <= (dst[Q_BITS] == STATUS_OK) ? sat_val : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else if (advance) begin
      vld          <= {vld[NST-2:0], pop};
      result_valid <= vld[NST-1];
    end
  end

endmodule

`default_nettype wire

### src/quadratic_lagrange_interpolator.sv
// ----------------------------------------------------------------------------
// quadratic_lagrange_interpolator - second-order Lagrange interpolation
// Q16.16 value of the parabola through three timestamped samples.
// ----------------------------------------------------------------------------
// Usage:
//   The query channel (query_valid / query_stall / query) carries one query
//   time and three samples per transaction; the result channel
//   (result_valid / result_stall / result) returns one value and status.
//   A transaction moves on a clock edge with valid high and stall low.
//   Throughput: one transaction per cycle while result_stall is low, held by a
//   fully pipelined divider that resolves one quotient bit per stage (33 stages).
//   Path from the accepting edge to result valid: the queue slot is written
//   at acceptance, then 5 product, sum and seed stages, 33 divider stages
//   and the output register.
//   Timestamp checks run in the front; failing queries return value zero
//   with the matching status but still pass the pipeline in order.
//   When result_stall and result_valid are high the whole back pipeline holds; the 4-entry
//   queue keeps accepting until full, then query_stall rises.
//   Reset (rst, synchronous) empties the queue and clears all valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quadratic_lagrange_interpolator
  import qli_pkg::*;
#(
  parameter int SPAN_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        query_valid,
  output logic        query_stall,
  input  qli_query_t  query,
  output logic        result_valid,
  input  logic        result_stall,
  output qli_result_t result
);

  localparam int CMD_W = 3 + 96 + 3 + 6 * SPAN_BITS;

  logic [CMD_W-1:0] cmd, head;
  logic empty, full, pop;

  // classify and prepare operands
  qli_front #(.SPAN_BITS(SPAN_BITS), .CMD_W(CMD_W)) u_front (
    .query (query),
    .cmd   (cmd)
  );

  // hold prepared queries while the back pipeline stalls
  qli_queue #(.W(CMD_W), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (query_valid),
    .push_data (cmd),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  assign query_stall = full;

  // multiply, divide, round, saturate
  qli_back #(.SPAN_BITS(SPAN_BITS), .CMD_W(CMD_W)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

### src/qli_checker.sv
// ----------------------------------------------------------------------------
// qli_checker - port-level assertions for the interpolator
// Watches the result channel and reset behavior at the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qli_checker
  import qli_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        query_valid,
  input logic        query_stall,
  input qli_query_t  query,
  input logic        result_valid,
  input logic        result_stall,
  input qli_result_t result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status != STATUS_OK |-> result.result_value == '0)
    else $error("error result not zero");

  a_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.status <= STATUS_SPAN)
    else $error("status out of range");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid && !query_stall)
    else $error("outputs active after reset");

endmodule

bind quadratic_lagrange_interpolator qli_checker u_qli_checker (.*);

`default_nettype wire

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench of the quadratic Lagrange interpolator
// Sends query transactions and predicts each Q16.16 result and status.
// Random gaps and stalls on both sides, and a watchdog against hangs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import qli_pkg::*;

  localparam int          SPAN_BITS  = 24;
  localparam logic [47:0] TIME_MAX   = 48'hFFFF_FFFF_FFFF;
  localparam int          IDLE_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        query_valid = 1'b0;
  logic        query_stall;
  qli_query_t  query = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  qli_result_t result;

  qli_result_t pending_results[$];
  int          mismatch_count = 0;
  int          idle_cycles = 0;
  bit          stall_quiet = 1'b0;

  always #2 clk = ~clk;

  quadratic_lagrange_interpolator #(.SPAN_BITS(SPAN_BITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .query_valid  (query_valid),
    .query_stall  (query_stall),
    .query        (query),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Exact interpolation: one common-denominator numerator, one division,
  // round half away from zero, then saturate to the Q16.16 range.
  function automatic qli_result_t interpolate(qli_query_t q);
    qli_result_t         r;
    logic [47:0]         lo, hi;
    logic signed [191:0] x, h1, h2, d, v0, v1, v2, num;
    logic [191:0]        mag, den, quo, rem;
    bit                  neg;
    r  = '0;
    lo = q.time_a;
    if (q.time_b < lo) lo = q.time_b;
    if (q.time_c < lo) lo = q.time_c;
    hi = q.time_a;
    if (q.time_b > hi) hi = q.time_b;
    if (q.time_c > hi) hi = q.time_c;
    if (q.time_a == q.time_b || q.time_a == q.time_c || q.time_b == q.time_c)
      r.status = STATUS_EQUAL;
    else if (q.query_time < lo || q.query_time > hi)
      r.status = STATUS_RANGE;
    else if (!(q.time_a < q.time_b && q.time_b < q.time_c))
      r.status = STATUS_ORDER;
    else if (48'(q.time_c - q.time_a) >= (48'd1 << SPAN_BITS))
      r.status = STATUS_SPAN;
    else
      r.status = STATUS_OK;
    if (r.status != STATUS_OK) return r;

    x   = $signed({144'd0, 48'(q.query_time - q.time_a)});
    h1  = $signed({144'd0, 48'(q.time_b - q.time_a)});
    h2  = $signed({144'd0, 48'(q.time_c - q.time_a)});
    d   = h2 - h1;
    v0  = 192'(q.value_a);
    v1  = 192'(q.value_b);
    v2  = 192'(q.value_c);
    num = v0 * (x - h1) * (x - h2) * d + v1 * x * (h2 - x) * h2
        + v2 * x * (x - h1) * h1;
    neg = num < 0;
    mag = neg ? 192'(-num) : 192'(num);
    den = 192'(h1 * h2 * d);
    quo = mag / den;
    rem = mag % den;
    if (rem * 2 >= den) quo = quo + 1;
    if (neg)
      r.result_value = (quo > 192'h8000_0000) ? 32'sh8000_0000 : -$signed(quo[31:0]);
    else
      r.result_value = (quo > 192'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(quo[31:0]);
    return r;
  endfunction

  // Gap length: mostly zero or short, now and then long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Drive one transaction and record its expected result at acceptance.
  task automatic send_query(qli_query_t q);
    int gap;
    @(negedge clk);
    query_valid <= 1'b1;
    query       <= q;
    do @(posedge clk); while (query_stall);
    pending_results.push_back(interpolate(q));
    gap = stall_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      query_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic qli_query_t build_query(logic [47:0] qt, logic [47:0] ta,
                                             logic [31:0] va, logic [47:0] tb,
                                             logic [31:0] vb, logic [47:0] tc,
                                             logic [31:0] vc);
    qli_query_t q;
    q.query_time = qt;
    q.time_a = ta; q.value_a = va;
    q.time_b = tb; q.value_b = vb;
    q.time_c = tc; q.value_c = vc;
    return q;
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [47:0] random_time();
    return 48'({$urandom, $urandom});
  endfunction

  // Well-formed triple with random span; a few spans lie just below, at or past the limit.
  function automatic qli_query_t random_good_query();
    logic [47:0] span, h1, t0;
    int          sb;
    sb = $urandom_range(2, SPAN_BITS);
    span = 48'($urandom_range(2, (32'd1 << sb) - 1));
    if ($urandom_range(0, 29) == 0)
      span = (48'd1 << SPAN_BITS) + 48'($urandom_range(0, 3)) - 48'd1;
    h1 = 48'($urandom_range(1, 32'(span) - 1));
    t0 = random_time();
    if ($urandom_range(0, 9) == 0) t0 = TIME_MAX - span;
    if ($urandom_range(0, 9) == 0) t0 = 48'($urandom_range(0, 3));
    if (t0 > TIME_MAX - span) t0 = TIME_MAX - span;
    return build_query(t0 + 48'($urandom_range(0, 32'(span))), t0, random_value(),
                       t0 + h1, random_value(), t0 + span, random_value());
  endfunction

  // Broken triples: shuffled order, duplicate times, query outside, or noise.
  function automatic qli_query_t random_bad_query();
    qli_query_t  q;
    logic [47:0] tmp;
    q = random_good_query();
    case ($urandom_range(0, 4))
      0: begin tmp = q.time_a; q.time_a = q.time_c; q.time_c = tmp; end
      1: begin tmp = q.time_b; q.time_b = q.time_a; q.time_a = tmp; end
      2: q.time_b = ($urandom_range(0, 1) != 0) ? q.time_a : q.time_c;
      3: q.query_time = ($urandom_range(0, 1) != 0) ? q.time_c + 48'd1
                                                    : q.time_a - 48'd1;
      default: q = build_query(random_time(), random_time(), $urandom,
                               random_time(), $urandom,
                               random_time(), $urandom);
    endcase
    return q;
  endfunction

  task automatic test_status_codes();
    send_query(build_query(48'd10, 48'd5, 32'h1_0000, 48'd5, 32'h2_0000, 48'd20, 1));
    send_query(build_query(48'd10, 48'd5, 32'h1_0000, 48'd12, 32'h2_0000, 48'd12, 1));
    send_query(build_query(48'd4, 48'd5, 32'h1_0000, 48'd8, 32'h2_0000, 48'd20, 1));
    send_query(build_query(48'd21, 48'd5, 32'h1_0000, 48'd8, 32'h2_0000, 48'd20, 1));
    send_query(build_query(48'd10, 48'd20, 32'h1_0000, 48'd8, 32'h2_0000, 48'd5, 1));
    send_query(build_query(48'd10, 48'd5, 32'h1_0000, 48'd20, 32'h2_0000, 48'd8, 1));
    // span exactly at the limit, and one tick below it
    send_query(build_query(48'd7, 48'd0, 32'h1_0000, 48'd3,
                           32'h2_0000, 48'd1 << SPAN_BITS, 1));
    send_query(build_query(48'd7, 48'd0, 32'h1_0000, 48'd3,
                           32'h2_0000, (48'd1 << SPAN_BITS) - 1, 1));
    send_query(build_query(TIME_MAX, TIME_MAX - 2, $urandom, TIME_MAX - 1,
                           $urandom, TIME_MAX, $urandom));
  endtask

  task automatic test_sample_points();
    // query on each sample, between samples, with full-scale values
    send_query(build_query(48'd100, 48'd100, 32'h8000_0000, 48'd150, 32'h7FFF_FFFF,
                           48'd400, 32'h0));
    send_query(build_query(48'd150, 48'd100, 32'h8000_0000, 48'd150, 32'h7FFF_FFFF,
                           48'd400, 32'h0));
    send_query(build_query(48'd400, 48'd100, 32'h8000_0000, 48'd150, 32'h7FFF_FFFF,
                           48'd400, 32'h0));
    send_query(build_query(48'd1, 48'd0, 32'h1_0000, 48'd2, 32'h3_0000, 48'd4, 32'h7));
    send_query(build_query(48'd3, 48'd0, 32'hFFFF_0001, 48'd2, 32'h5, 48'd4, 32'h3));
  endtask

  task automatic test_saturation();
    // full-scale samples that bring the parabola to or near both rails
    send_query(build_query(48'd1, 48'd0, 32'h7FFF_FFFF, 48'd2, 32'h8000_0000,
                           48'd3, 32'h7FFF_FFFF));
    send_query(build_query(48'd1, 48'd0, 32'h8000_0000, 48'd2, 32'h7FFF_FFFF,
                           48'd3, 32'h8000_0000));
    send_query(build_query(48'd1, 48'd0, 32'h8000_0000, 48'd1 << 23, 32'h7FFF_FFFF,
                           (48'd1 << SPAN_BITS) - 1, 32'h8000_0000));
    send_query(build_query((48'd1 << SPAN_BITS) - 2, 48'd0, 32'h7FFF_FFFF, 48'd1,
                           32'h8000_0000, (48'd1 << SPAN_BITS) - 1, 32'h7FFF_FFFF));
  endtask

  task automatic test_random();
    for (int n = 0; n < 600; n++) begin
      // every so often, run a burst with no idling on either side
      if (n % 100 == 0) stall_quiet = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 99) < 80) send_query(random_good_query());
      else send_query(random_bad_query());
    end
    stall_quiet = 1'b0;
  endtask

  // Back-pressure on the result channel; changes only at the falling edge.
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      gap = stall_quiet ? 0 : pick_gap();
      if (gap > 0) begin
        result_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      result_stall <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  // Compare each accepted result with the oldest pending expectation.
  always @(posedge clk) begin
    qli_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time,
                 result.result_value, result.status);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.result_value !== want.result_value) begin
          $display("%0t: result_value expected %h actual %h", $time,
                   want.result_value, result.result_value);
          mismatch_count++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   want.status, result.status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if (rst || (query_valid && !query_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_status_codes();
    test_sample_points();
    test_saturation();
    test_random();
    @(negedge clk);
    query_valid <= 1'b0;
    // drain the pipeline, then allow for its latency
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
